/* hdl/price_tick_size_estimator_top_defines.svh */
// ----------------------------------------------------------------------------
// Price tick size estimator assertion macros
// Shared assertion helpers for the estimator top level.
// ----------------------------------------------------------------------------
`ifndef PRICE_TICK_SIZE_ESTIMATOR_TOP_DEFINES_SVH
`define PRICE_TICK_SIZE_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define PTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/pte_pkg.sv */
// ----------------------------------------------------------------------------
// Price tick size estimator package
// Widths, register indexes, result codes and the decimal unit table.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int MAX_PRICES = 1024;
	localparam int ADDR_W     = $clog2(MAX_PRICES);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int PRICE_W    = 48;
	localparam int TICK_W     = 48;
	localparam int UNIT_W     = 27;
	localparam int DEC_W      = 4;
	localparam int THR_W      = 9;
	localparam int CFG_W      = 9;
	localparam logic [DEC_W-1:0] DECIMALS = 4'd8;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	localparam logic REG_MAX_DECIMALS = 1'b0;
	localparam logic REG_THRESHOLD    = 1'b1;

	localparam logic [1:0] FB_NONE   = 2'd0;
	localparam logic [1:0] FB_PRICES = 2'd1;
	localparam logic [1:0] FB_LEVELS = 2'd2;

	function automatic logic [UNIT_W-1:0] pow10(input logic [DEC_W-1:0] e);
		logic [UNIT_W-1:0] r;
		case (e)
			4'd0: r = 27'd1;
			4'd1: r = 27'd10;
			4'd2: r = 27'd100;
			4'd3: r = 27'd1000;
			4'd4: r = 27'd10000;
			4'd5: r = 27'd100000;
			4'd6: r = 27'd1000000;
			4'd7: r = 27'd10000000;
			4'd8: r = 27'd100000000;
			default: r = 27'd1;
		endcase
		return r;
	endfunction

endpackage

/* hdl/pte_ifs.sv */
// ----------------------------------------------------------------------------
// Price tick size estimator channels
// Valid/ready channels for price items and result items.
// ----------------------------------------------------------------------------
interface pte_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [pte_pkg::PRICE_W-1:0] price;
	logic                             finite;
	logic                             last;
	modport source (output valid, price, finite, last, input ready);
	modport sink (input valid, price, finite, last, output ready);
endinterface

interface pte_out_if;
	logic                            valid;
	logic                            ready;
	logic [pte_pkg::TICK_W-1:0]      tick;
	logic [pte_pkg::DEC_W-1:0]       decimals_used;
	logic [1:0]                      fallback;
	logic                            overflow;
	modport source (output valid, tick, decimals_used, fallback, overflow, input ready);
	modport sink (input valid, tick, decimals_used, fallback, overflow, output ready);
endinterface

/* hdl/pte_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/pte_div.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Divides a price magnitude by a decimal unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pte_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pte_pkg::PRICE_W-1:0]   dividend,
	input  logic [pte_pkg::UNIT_W-1:0]    divisor,
	output logic                          done,
	output logic [pte_pkg::PRICE_W-1:0]   quot,
	output logic [pte_pkg::UNIT_W-1:0]    rem
);

	logic                         busy_q;
	logic                         done_q;
	logic [5:0]                   cnt_q;
	logic [pte_pkg::PRICE_W-1:0]  dd_q;
	logic [pte_pkg::UNIT_W-1:0]   dv_q;
	logic [pte_pkg::UNIT_W-1:0]   r_q;
	logic [pte_pkg::UNIT_W:0]     trial;
	logic                         fits;

	assign trial = {r_q, dd_q[pte_pkg::PRICE_W-1]};
	assign fits  = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(pte_pkg::PRICE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dd_q <= dividend;
			dv_q <= divisor;
			r_q  <= '0;
		end else if (busy_q) begin
			r_q  <= fits ? pte_pkg::UNIT_W'(trial - {1'b0, dv_q})
				: trial[pte_pkg::UNIT_W-1:0];
			dd_q <= {dd_q[pte_pkg::PRICE_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dd_q;
	assign rem  = r_q;

endmodule

/* hdl/price_tick_size_estimator_top.sv */
// ----------------------------------------------------------------------------
// Price tick size estimator
// Stores a run of prices, picks a decimal scale and reports the tick as the
// GCD of the rounded level differences, multiplied back by the decimal unit.
// Loading accepts one item per cycle; ready stays high until the last item.
// After the last item the result follows a divide per price for each scale
// tried, a rounding divide per price, the binary GCD steps and a shift-add
// multiply; all divides share the single divider.
// Reset is asynchronous and clears the count, flags and sequencer, no sweep.
// ----------------------------------------------------------------------------
`include "price_tick_size_estimator_top_defines.svh"

module price_tick_size_estimator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	pte_in_if.sink                       samples,
	pte_out_if.source                    result,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [pte_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_GO    = 4'd3;
	localparam logic [3:0] S_WAIT  = 4'd4;
	localparam logic [3:0] S_GCD   = 4'd5;
	localparam logic [3:0] S_MULI  = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	localparam int LVL_W = pte_pkg::PRICE_W + 1;
	localparam int ACC_W = LVL_W + pte_pkg::UNIT_W;

	logic [3:0]                    state_q;
	logic [pte_pkg::DEC_W-1:0]     maxdec_q;
	logic [pte_pkg::THR_W-1:0]     thr_q;
	logic [pte_pkg::CNT_W-1:0]     cnt_q;
	logic                          dropped_q;
	logic [pte_pkg::CNT_W-1:0]     idx_q;
	logic [pte_pkg::DEC_W-1:0]     j_q;
	logic [pte_pkg::DEC_W-1:0]     k_q;
	logic [pte_pkg::CNT_W-1:0]     ok_q;
	logic                          round_q;
	logic                          neg_q;
	logic signed [LVL_W-1:0]       ref_q;
	logic [LVL_W-1:0]              g_q;
	logic [LVL_W-1:0]              ga_q;
	logic [LVL_W-1:0]              gb_q;
	logic [5:0]                    sh_q;
	logic [ACC_W-1:0]              acc_q;
	logic [ACC_W-1:0]              mc_q;
	logic [pte_pkg::UNIT_W-1:0]    mr_q;
	logic [pte_pkg::TICK_W-1:0]    tick_q;
	logic [pte_pkg::DEC_W-1:0]     dec_q;
	logic [1:0]                    fb_q;
	logic                          ovf_q;

	logic                          in_acc;
	logic                          store;
	logic [pte_pkg::PRICE_W-1:0]   rdata;
	logic                          rneg;
	logic [pte_pkg::PRICE_W-1:0]   rmag;
	logic [pte_pkg::DEC_W-1:0]     kmax;
	logic [pte_pkg::DEC_W-1:0]     cur_k;
	logic [pte_pkg::UNIT_W-1:0]    unit;
	logic [pte_pkg::UNIT_W-1:0]    half;
	logic                          div_start;
	logic [pte_pkg::PRICE_W-1:0]   div_dd;
	logic                          div_done;
	logic [pte_pkg::PRICE_W-1:0]   div_q;
	logic [pte_pkg::UNIT_W-1:0]    div_r;
	logic [pte_pkg::CNT_W-1:0]     ok_nx;
	logic [pte_pkg::CNT_W-1:0]     idx_nx;
	logic                          pass;
	logic signed [LVL_W-1:0]       lvl;
	logic signed [LVL_W:0]         diff;
	logic [LVL_W-1:0]              dmag;

	assign in_acc = samples.valid && samples.ready;
	assign store  = in_acc && samples.finite && (cnt_q < pte_pkg::CNT_W'(pte_pkg::MAX_PRICES));

	pte_ram #(.WIDTH(pte_pkg::PRICE_W), .DEPTH(pte_pkg::MAX_PRICES)) u_store (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[pte_pkg::ADDR_W-1:0]),
		.wdata (samples.price),
		.raddr (idx_q[pte_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign rneg  = rdata[pte_pkg::PRICE_W-1];
	assign rmag  = rneg ? (~rdata + 1'b1) : rdata;
	assign kmax  = (maxdec_q > pte_pkg::DECIMALS) ? pte_pkg::DECIMALS : maxdec_q;
	assign cur_k = round_q ? k_q : j_q;
	assign unit  = pte_pkg::pow10(pte_pkg::DECIMALS - cur_k);
	assign half  = unit >> 1;
	assign div_start = (state_q == S_GO);
	assign div_dd    = round_q ? (rmag + pte_pkg::PRICE_W'(half)) : rmag;

	pte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dd),
		.divisor  (unit),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	assign ok_nx  = ok_q + pte_pkg::CNT_W'(div_r == '0);
	assign idx_nx = idx_q + 1'b1;
	assign pass   = {1'b0, ok_nx, 8'b0} >= 20'(thr_q * cnt_q);
	assign lvl    = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
	assign diff   = {lvl[LVL_W-1], lvl} - {ref_q[LVL_W-1], ref_q};
	assign dmag   = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxdec_q <= 4'd8;
			thr_q    <= 9'd243;
		end else if (cfg_we) begin
			if (cfg_index == pte_pkg::REG_MAX_DECIMALS) begin
				maxdec_q <= cfg_wdata[pte_pkg::DEC_W-1:0];
			end else begin
				thr_q <= cfg_wdata[pte_pkg::THR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			g_q       <= '0;
			idx_q     <= '0;
			j_q       <= '0;
			k_q       <= '0;
			ok_q      <= '0;
			round_q   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (store) begin
							cnt_q <= cnt_q + 1'b1;
						end else if (samples.finite) begin
							dropped_q <= 1'b1;
						end
						if (samples.last) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					idx_q   <= '0;
					j_q     <= '0;
					ok_q    <= '0;
					round_q <= 1'b0;
					g_q     <= '0;
					if (cnt_q < pte_pkg::CNT_W'(2)) begin
						tick_q  <= pte_pkg::TICK_W'(pte_pkg::pow10(pte_pkg::DECIMALS - 4'd2));
						dec_q   <= 4'd2;
						fb_q    <= pte_pkg::FB_PRICES;
						ovf_q   <= dropped_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_GO;
				end
				S_GO: begin
					neg_q   <= rneg;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						if (!round_q) begin
							if (idx_nx == cnt_q) begin
								idx_q <= '0;
								ok_q  <= '0;
								if (pass) begin
									k_q     <= j_q;
									round_q <= 1'b1;
								end else if (j_q == kmax) begin
									k_q     <= 4'd2;
									round_q <= 1'b1;
								end else begin
									j_q <= j_q + 1'b1;
								end
							end else begin
								idx_q <= idx_nx;
								ok_q  <= ok_nx;
							end
							state_q <= S_RD;
						end else begin
							idx_q <= idx_nx;
							if (idx_q == '0) begin
								ref_q <= lvl;
							end
							if (idx_q != '0 && dmag != '0 && g_q != '0) begin
								ga_q    <= g_q;
								gb_q    <= dmag;
								sh_q    <= '0;
								state_q <= S_GCD;
							end else begin
								if (idx_q != '0 && dmag != '0) begin
									g_q <= dmag;
								end
								state_q <= (idx_nx == cnt_q) ? S_MULI : S_RD;
							end
						end
					end
				end
				S_GCD: begin
					if (ga_q == '0 || gb_q == '0) begin
						g_q     <= (ga_q | gb_q) << sh_q;
						state_q <= (idx_q == cnt_q) ? S_MULI : S_RD;
					end else if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q >= gb_q) begin
						ga_q <= ga_q - gb_q;
					end else begin
						gb_q <= gb_q - ga_q;
					end
				end
				S_MULI: begin
					dec_q <= k_q;
					ovf_q <= dropped_q;
					if (g_q == '0) begin
						tick_q  <= pte_pkg::TICK_W'(unit);
						fb_q    <= pte_pkg::FB_LEVELS;
						state_q <= S_OUT;
					end else begin
						acc_q   <= '0;
						mc_q    <= ACC_W'(g_q);
						mr_q    <= unit;
						fb_q    <= pte_pkg::FB_NONE;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mr_q == '0) begin
						tick_q  <= (acc_q[ACC_W-1:pte_pkg::TICK_W] != '0) ? pte_pkg::TICK_MAX
							: acc_q[pte_pkg::TICK_W-1:0];
						state_q <= S_OUT;
					end else begin
						if (mr_q[0]) begin
							acc_q <= acc_q + mc_q;
						end
						mc_q <= mc_q << 1;
						mr_q <= mr_q >> 1;
					end
				end
				S_OUT: begin
					if (result.ready) begin
						cnt_q     <= '0;
						dropped_q <= 1'b0;
						g_q       <= '0;
						state_q   <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign samples.ready        = (state_q == S_LOAD);
	assign result.valid         = (state_q == S_OUT);
	assign result.tick          = tick_q;
	assign result.decimals_used = dec_q;
	assign result.fallback      = fb_q;
	assign result.overflow      = ovf_q;

	`PTE_ASSERT_NOW(a_ready_excl, samples.ready, !result.valid, "ready while result pending")
	`PTE_ASSERT_NEXT(a_clear, result.valid && result.ready, samples.ready && cnt_q == '0, "run not cleared after result")
	`PTE_ASSERT_NOW(a_fb_prices, result.valid && result.fallback == pte_pkg::FB_PRICES, result.decimals_used == 4'd2, "short run scale not two")
	`PTE_ASSERT_NOW(a_div_idle, div_start, !div_done, "divider restarted while finishing")

endmodule
